// ===== rtl/psc_pkg.sv =====
`timescale 1ns / 1ps

package psc_pkg;

  // Stream and port widths
  localparam int RAW_W      = 24;
  localparam int IN_W       = 48;   // two raw fields, already whole bytes
  localparam int TEMP_W     = 19;
  localparam int PRES_W     = 32;
  localparam int OUT_W      = 56;   // 51 payload bits padded to 7 bytes
  localparam int CAL_W      = 16;
  localparam int CFG_ADDR_W = 3;

  // Calibration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SENS      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SENS_TC   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_TC = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TREF      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_TEMPSENS  = 3'd5;

  // 20.00 C base temperature, and the -15.00 C knee expressed as an offset from it
  localparam logic signed [19:0] TEMP_BASE  = 20'sd2000;
  localparam logic signed [17:0] COLD_KNEE  = -18'sd3500;
  localparam logic signed [18:0] KNEE_SHIFT = 19'sd3500;

endpackage

// ===== rtl/pressure_sensor_compensation.sv =====
`timescale 1ns / 1ps

// Second-order compensation of a 14-bar piezo-resistive pressure sensor.
//
// Channels:
//   cfg_*   : write port for the six factory calibration words (index 0..5,
//             higher indexes ignored). Write only while the pipe is empty.
//   s_axis  : one beat = one raw conversion pair (D1 pressure, D2 temperature).
//   m_axis  : one beat = one compensated result (0.01 C, 0.1 mbar).
// Throughput: one beat per cycle. Every stage holds one item; valid bits
//   travel with the data. The pipe stalls as a whole only when the output
//   register is full and m_axis_tready is low, so s_axis_tready stays high
//   while the output register is empty or being drained.
// Reset (rst, synchronous): all valid bits and calibration words clear.
// Stall: all stages hold; no beat is lost or repeated.
// Stage plan: 1 dT, 2 products with dT, 3 truncating shifts and first-order
// OFF/SENS, 4 squares and raw TEMP-T2, 5 OFF2/SENS2, 6 final OFF/SENS,
// 7 D1*SENS split in two partial products, 8 recombine, 9 subtract OFF*2^21,
// 10 divide by 2^36 into the output register.
// The arithmetic bounds keep TEMP inside 19 bits (about -227400..118700) and
// P inside +-2^26, so the output clamps never act and are left out.

module pressure_sensor_compensation (
  input  logic                             clk,
  input  logic                             rst,
  // calibration write port
  input  logic                             cfg_we,
  input  logic [psc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [psc_pkg::CAL_W-1:0]        cfg_data,
  // raw input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [psc_pkg::IN_W-1:0]         s_axis_tdata,   // [23:0] raw_pressure,
                                                           // [47:24] raw_temperature
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [psc_pkg::OUT_W-1:0]        m_axis_tdata    // [18:0] temperature_centi,
                                                           // [50:19] pressure_value, [55:51] zero
);
  import psc_pkg::*;

  localparam int NSTAGE = 10;

  // rounding biases for truncation toward zero of negative values
  localparam logic signed [41:0] BIAS7  = 42'sh7F;
  localparam logic signed [41:0] BIAS8  = 42'shFF;
  localparam logic signed [41:0] BIAS23 = 42'sh7FFFFF;
  localparam logic signed [63:0] BIAS36 = 64'shF_FFFF_FFFF;

  // ---------------------------------------------------------------- config
  logic [CAL_W-1:0] c1, c2, c3, c4, c5, c6;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
      c5 <= '0;
      c6 <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SENS:      c1 <= cfg_data;
        REG_OFFSET:    c2 <= cfg_data;
        REG_SENS_TC:   c3 <= cfg_data;
        REG_OFFSET_TC: c4 <= cfg_data;
        REG_TREF:      c5 <= cfg_data;
        REG_TEMPSENS:  c6 <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  logic [NSTAGE-1:0] vld;
  logic              en;

  assign en            = !vld[NSTAGE-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTAGE-2:0], s_axis_tvalid};
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic [RAW_W-1:0]  s1_d1;
  logic signed [24:0] s1_dt;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d1 <= s_axis_tdata[23:0];
      s1_dt <= $signed({1'b0, s_axis_tdata[47:24]}) - $signed({1'b0, c5, 8'b0});
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic [RAW_W-1:0]   s2_d1;
  logic signed [41:0] s2_pt, s2_poff, s2_psens;
  logic [47:0]        s2_dd;
  logic signed [49:0] dt_sq;

  assign dt_sq = s1_dt * s1_dt;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_d1    <= s1_d1;
      s2_pt    <= s1_dt * $signed({1'b0, c6});
      s2_poff  <= $signed({1'b0, c4}) * s1_dt;
      s2_psens <= $signed({1'b0, c3}) * s1_dt;
      s2_dd    <= dt_sq[47:0];   // dT^2 < 2^48
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic [RAW_W-1:0]   s3_d1;
  logic signed [17:0] s3_tdev;     // TEMP - 2000 before second order
  logic signed [35:0] s3_off1, s3_sens1;
  logic [16:0]        s3_t2c;      // 3*dT^2 / 2^33
  logic [13:0]        s3_t2h;      // 7*dT^2 / 2^37

  logic signed [41:0] t_bias, off_bias, sens_bias;
  logic signed [34:0] off_div;
  logic signed [33:0] sens_div;
  logic [49:0]        dd_x3;
  logic [50:0]        dd_x7;

  assign t_bias    = s2_pt    + (s2_pt[41]    ? BIAS23 : 42'sd0);
  assign off_bias  = s2_poff  + (s2_poff[41]  ? BIAS7  : 42'sd0);
  assign sens_bias = s2_psens + (s2_psens[41] ? BIAS8  : 42'sd0);
  assign off_div   = off_bias[41:7];
  assign sens_div  = sens_bias[41:8];
  assign dd_x3     = {2'b0, s2_dd} + {1'b0, s2_dd, 1'b0};
  assign dd_x7     = {s2_dd, 3'b0} - {3'b0, s2_dd};

  always_ff @(posedge clk) begin
    if (en) begin
      s3_d1    <= s2_d1;
      s3_tdev  <= t_bias[40:23];   // |dT*C6| < 2^40
      s3_off1  <= $signed({4'b0, c2, 16'b0}) + 36'(off_div);
      s3_sens1 <= $signed({5'b0, c1, 15'b0}) + 36'(sens_div);
      s3_t2c   <= dd_x3[49:33];
      s3_t2h   <= dd_x7[50:37];
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic [RAW_W-1:0]   s4_d1;
  logic signed [35:0] s4_off1, s4_sens1;
  logic signed [18:0] s4_temp;
  logic [33:0]        s4_dev, s4_low;
  logic               s4_cold, s4_vcold;

  logic signed [35:0] dev_sq;
  logic signed [18:0] low_b;
  logic signed [37:0] low_sq;
  logic [16:0]        t2_sel;
  logic signed [19:0] temp0;

  assign dev_sq = s3_tdev * s3_tdev;
  assign low_b  = 19'(s3_tdev) + KNEE_SHIFT;
  assign low_sq = low_b * low_b;
  assign t2_sel = s3_tdev[17] ? s3_t2c : {3'b0, s3_t2h};
  assign temp0  = TEMP_BASE + 20'(s3_tdev) - $signed({3'b0, t2_sel});

  always_ff @(posedge clk) begin
    if (en) begin
      s4_d1    <= s3_d1;
      s4_off1  <= s3_off1;
      s4_sens1 <= s3_sens1;
      s4_temp  <= temp0[18:0];
      s4_dev   <= dev_sq[33:0];
      s4_low   <= low_sq[33:0];    // only used below the knee, where it is < 2^34
      s4_cold  <= s3_tdev[17];
      s4_vcold <= (s3_tdev < COLD_KNEE);
    end
  end

  // ---------------------------------------------------------------- stage 5
  logic [RAW_W-1:0]   s5_d1;
  logic signed [35:0] s5_off1, s5_sens1;
  logic signed [18:0] s5_temp;
  logic [37:0]        s5_off2;
  logic [36:0]        s5_sens2;

  logic [35:0] dev_x3;
  logic [36:0] dev_x5;
  logic [36:0] low_x7;
  logic [37:0] off2_n;
  logic [36:0] sens2_n;

  assign dev_x3 = {2'b0, s4_dev} + {1'b0, s4_dev, 1'b0};
  assign dev_x5 = {3'b0, s4_dev} + {1'b0, s4_dev, 2'b0};
  assign low_x7 = {s4_low, 3'b0} - {3'b0, s4_low};

  always_comb begin
    if (s4_cold) begin
      off2_n  = {3'b0, dev_x3[35:1]} + (s4_vcold ? {1'b0, low_x7} : 38'd0);
      sens2_n = {3'b0, dev_x5[36:3]} + (s4_vcold ? {1'b0, s4_low, 2'b0} : 37'd0);
    end else begin
      off2_n  = {8'b0, s4_dev[33:4]};
      sens2_n = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_d1    <= s4_d1;
      s5_off1  <= s4_off1;
      s5_sens1 <= s4_sens1;
      s5_temp  <= s4_temp;
      s5_off2  <= off2_n;
      s5_sens2 <= sens2_n;
    end
  end

  // ---------------------------------------------------------------- stage 6
  logic [RAW_W-1:0]   s6_d1;
  logic signed [18:0] s6_temp;
  logic signed [39:0] s6_off;
  logic signed [38:0] s6_sens;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_d1   <= s5_d1;
      s6_temp <= s5_temp;
      s6_off  <= 40'(s5_off1) - $signed({2'b0, s5_off2});
      s6_sens <= 39'(s5_sens1) - $signed({2'b0, s5_sens2});
    end
  end

  // ---------------------------------------------------------------- stage 7
  // D1*SENS as two partial products: low 19 bits unsigned, high 20 bits signed
  logic signed [18:0] s7_temp;
  logic signed [39:0] s7_off;
  logic [42:0]        s7_plo;
  logic signed [44:0] s7_phi;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_temp <= s6_temp;
      s7_off  <= s6_off;
      s7_plo  <= s6_d1 * s6_sens[18:0];
      s7_phi  <= $signed({1'b0, s6_d1}) * $signed(s6_sens[38:19]);
    end
  end

  // ---------------------------------------------------------------- stage 8
  logic signed [18:0] s8_temp;
  logic signed [63:0] s8_sum, s8_offs;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_temp <= s7_temp;
      s8_sum  <= (64'(s7_phi) <<< 19) + $signed({21'b0, s7_plo});
      s8_offs <= 64'(s7_off) <<< 21;
    end
  end

  // ---------------------------------------------------------------- stage 9
  logic signed [18:0] s9_temp;
  logic signed [63:0] s9_num;

  always_ff @(posedge clk) begin
    if (en) begin
      s9_temp <= s8_temp;
      s9_num  <= s8_sum - s8_offs;
    end
  end

  // ---------------------------------------------------------------- stage 10
  logic signed [63:0]       num_bias;
  logic signed [27:0]       p_div;
  logic [TEMP_W-1:0]        out_temp;
  logic signed [PRES_W-1:0] out_pres;

  assign num_bias = s9_num + (s9_num[63] ? BIAS36 : 64'sd0);
  assign p_div    = num_bias[63:36];

  always_ff @(posedge clk) begin
    if (en) begin
      out_temp <= s9_temp;
      out_pres <= 32'(p_div);
    end
  end

  assign m_axis_tdata = {5'b0, out_pres, out_temp};

endmodule
